// ===== design/ber_tlv_stream_parser_core_assert.svh =====
// Assertion macros shared by the parser modules.
`ifndef BER_TLV_STREAM_PARSER_CORE_ASSERT_SVH
`define BER_TLV_STREAM_PARSER_CORE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define BTP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Property that holds on the edge after the antecedent.
`define BTP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/btp_pkg.sv =====
package btp_pkg;

    localparam int MaxDepth = 8;
    localparam int DepW = $clog2(MaxDepth + 1);
    localparam int IdxW = (MaxDepth > 1) ? $clog2(MaxDepth) : 1;
    localparam int QDepth = 4;
    localparam int QPtrW = $clog2(QDepth);
    localparam int QCntW = $clog2(QDepth + 1);
    localparam logic [7:0] ShortLenMax = 8'd127;
    localparam logic [7:0] LenIndef = 8'h80;
    localparam logic [7:0] LenLongMax = 8'h84;
    localparam logic [7:0] TagConstructed = 8'h20;

    typedef enum logic [2:0] {
        EV_HEADER = 3'd0,
        EV_CONTENT = 3'd1,
        EV_PRIM_END = 3'd2,
        EV_CLOSE = 3'd3,
        EV_ERROR = 3'd4
    } t_event_kind;

    typedef enum logic [1:0] {
        ERR_LEN_FORM = 2'd0,
        ERR_OVERRUN = 2'd1,
        ERR_INT_LONG = 2'd2,
        ERR_STACK = 2'd3
    } t_error_code;

    typedef enum logic [1:0] {
        PH_TAG = 2'd0,
        PH_LEN1 = 2'd1,
        PH_LENN = 2'd2,
        PH_CONTENT = 2'd3
    } t_phase;

    // Engine sequencer states.
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EV2 = 2'd1,
        S_CLOSE = 2'd2
    } t_eng_state;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [7:0]  tag;
        logic [31:0] elem_length;
        logic [3:0]  depth;
        logic [7:0]  content_byte;
        logic [63:0] int_value;
        logic [1:0]  error_code;
        logic        last_result;
    } t_out_item;

    // Command from the front part: one accepted byte with its frame-start flag.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } t_cmd;

    function automatic logic is_int_tag(input logic [7:0] t);
        return (t == 8'h02) || (t == 8'h41) || (t == 8'h42) || (t == 8'h43);
    endfunction

endpackage

// ===== design/btp_if.sv =====
interface btp_in_if import btp_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface btp_out_if import btp_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== design/btp_queue.sv =====
module btp_queue import btp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_data
);
    t_cmd             r_mem [QDepth];
    logic [QPtrW-1:0] r_wr;
    logic [QPtrW-1:0] r_rd;
    logic [QCntW-1:0] r_cnt;

    assign o_full  = (r_cnt == QCntW'(QDepth));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) r_wr <= r_wr + 1'b1;
            if (i_pop && !o_empty) r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + QCntW'(i_push && !o_full) - QCntW'(i_pop && !o_empty);
        end
    end
endmodule

// ===== design/btp_engine.sv =====
`include "ber_tlv_stream_parser_core_assert.svh"
module btp_engine import btp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_empty,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    output logic      o_busy,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);
    // Engine sequencer: take byte, emit events one per cycle while the output is free, walk closes.
    t_eng_state r_st, n_st;
    t_phase      r_phase, n_phase;
    logic [7:0]  r_tag, n_tag;
    logic [31:0] r_len, n_len;
    logic [2:0]  r_lbl, n_lbl;
    logic [31:0] r_cleft, n_cleft;
    logic [63:0] r_acc, n_acc;
    logic [31:0] r_pos, n_pos;
    logic [DepW-1:0] r_lvl, n_lvl;
    logic        r_err, n_err;
    logic [31:0] r_cend [MaxDepth];
    logic [7:0]  r_ctag [MaxDepth];
    logic        w_push;
    logic [31:0] w_push_end;
    t_out_item   r_out, n_out;
    logic        r_ov, n_ov;
    t_out_item   r_pend, n_pend;

    logic [31:0] w_top_end, w_room;
    logic [IdxW-1:0] w_top;
    logic        w_has_parent, w_out_free, w_close_now;

    assign w_out_free = !r_ov || i_ready;
    assign o_valid = r_ov;
    assign o_item = r_out;
    assign o_busy = (r_st != S_IDLE) || r_ov;
    assign w_top = IdxW'(r_lvl - 1'b1);
    assign w_has_parent = (r_lvl != '0);
    assign w_top_end = r_cend[w_top];
    assign w_close_now = w_has_parent && (w_top_end == r_pos);

    function automatic t_out_item mk(input t_event_kind k, input logic [7:0] t,
            input logic [31:0] l, input logic [DepW-1:0] d, input logic [7:0] c,
            input logic [63:0] v, input t_error_code e, input logic last);
        t_out_item x;
        x.event_kind = k;
        x.tag = t;
        x.elem_length = l;
        x.depth = 4'(d);
        x.content_byte = c;
        x.int_value = v;
        x.error_code = e;
        x.last_result = last;
        return x;
    endfunction

    always_comb begin
        logic [7:0]  b;
        logic        rst;
        t_phase      ph;
        logic [31:0] pos, cur_end;
        logic [DepW-1:0] lvl;
        logic        exh;
        logic        do_fin;
        t_out_item   e1;
        logic        have1, have2, want_close;
        b = i_cmd.data_byte;
        rst = i_cmd.frame_start;
        n_st = r_st; n_phase = r_phase; n_tag = r_tag; n_len = r_len; n_lbl = r_lbl;
        n_cleft = r_cleft; n_acc = r_acc; n_pos = r_pos; n_lvl = r_lvl; n_err = r_err;
        n_out = r_out; n_ov = r_ov && !i_ready; n_pend = r_pend;
        o_pop = 1'b0; w_push = 1'b0; w_push_end = '0;
        w_room = '0;
        ph = r_phase; pos = r_pos; lvl = r_lvl; cur_end = w_top_end;
        exh = 1'b0; do_fin = 1'b0; e1 = '0; have1 = 1'b0; have2 = 1'b0;
        want_close = 1'b0;
        case (r_st)
            S_IDLE: begin
                if (!i_empty && w_out_free) begin
                    o_pop = 1'b1;
                    if (rst) begin
                        ph = PH_TAG; pos = '0; lvl = '0;
                        n_tag = '0; n_len = '0; n_lbl = '0; n_cleft = '0; n_acc = '0;
                        n_err = 1'b0;
                    end
                    if (!(r_err && !rst)) begin
                        pos = pos + 1'b1;
                        n_pos = pos;
                        exh = (lvl != '0) && (cur_end == pos);
                        w_room = cur_end - pos;
                        case (ph)
                            PH_TAG: begin
                                n_tag = b; n_len = '0; n_phase = PH_LEN1;
                                if (exh) begin
                                    e1 = mk(EV_ERROR, b, '0, lvl, '0, '0, ERR_OVERRUN, 1'b1);
                                    have1 = 1'b1; n_err = 1'b1;
                                end
                            end
                            PH_LEN1: begin
                                if (b <= ShortLenMax) begin
                                    n_len = {24'd0, b}; do_fin = 1'b1;
                                end else if (b == LenIndef || b > LenLongMax) begin
                                    e1 = mk(EV_ERROR, n_tag, n_len, lvl, '0, '0,
                                        ERR_LEN_FORM, 1'b1);
                                    have1 = 1'b1; n_err = 1'b1;
                                end else begin
                                    n_len = '0; n_lbl = b[2:0]; n_phase = PH_LENN;
                                    if (exh) begin
                                        e1 = mk(EV_ERROR, n_tag, '0, lvl, '0, '0,
                                            ERR_OVERRUN, 1'b1);
                                        have1 = 1'b1; n_err = 1'b1;
                                    end
                                end
                            end
                            PH_LENN: begin
                                n_len = {n_len[23:0], b};
                                n_lbl = n_lbl - 1'b1;
                                if (n_lbl == '0) do_fin = 1'b1;
                                else if (exh) begin
                                    e1 = mk(EV_ERROR, n_tag, n_len, lvl, '0, '0,
                                        ERR_OVERRUN, 1'b1);
                                    have1 = 1'b1; n_err = 1'b1;
                                end
                            end
                            default: begin
                                e1 = mk(EV_CONTENT, n_tag, n_len, lvl, b, '0,
                                    ERR_LEN_FORM, 1'b1);
                                have1 = 1'b1;
                                if (is_int_tag(n_tag)) n_acc = {n_acc[55:0], b};
                                n_cleft = n_cleft - 1'b1;
                                if (n_cleft == '0) begin
                                    have2 = 1'b1;
                                    n_pend = mk(EV_PRIM_END, n_tag, n_len, lvl, '0,
                                        is_int_tag(n_tag) ? n_acc : 64'd0,
                                        ERR_LEN_FORM, 1'b1);
                                    want_close = 1'b1;
                                end
                            end
                        endcase
                        if (do_fin) begin
                            if (lvl != '0 && n_len > w_room) begin
                                e1 = mk(EV_ERROR, n_tag, n_len, lvl, '0, '0,
                                    ERR_OVERRUN, 1'b1);
                                have1 = 1'b1; n_err = 1'b1;
                            end else if ((n_tag & TagConstructed) != '0) begin
                                if (lvl >= DepW'(MaxDepth)) begin
                                    e1 = mk(EV_ERROR, n_tag, n_len, lvl, '0, '0,
                                        ERR_STACK, 1'b1);
                                    have1 = 1'b1; n_err = 1'b1;
                                end else begin
                                    e1 = mk(EV_HEADER, n_tag, n_len, lvl, '0, '0,
                                        ERR_LEN_FORM, 1'b1);
                                    have1 = 1'b1;
                                    w_push = 1'b1; w_push_end = pos + n_len;
                                    lvl = lvl + 1'b1;
                                    n_phase = PH_TAG;
                                    // Only an empty container ends at this byte.
                                    want_close = (n_len == '0);
                                end
                            end else if (is_int_tag(n_tag) && n_len > 32'd8) begin
                                e1 = mk(EV_ERROR, n_tag, n_len, lvl, '0, '0,
                                    ERR_INT_LONG, 1'b1);
                                have1 = 1'b1; n_err = 1'b1;
                            end else begin
                                e1 = mk(EV_HEADER, n_tag, n_len, lvl, '0, '0,
                                    ERR_LEN_FORM, 1'b1);
                                have1 = 1'b1;
                                n_cleft = n_len; n_acc = '0;
                                if (n_len == '0) begin
                                    have2 = 1'b1;
                                    n_pend = mk(EV_PRIM_END, n_tag, '0, lvl, '0, '0,
                                        ERR_LEN_FORM, 1'b1);
                                    want_close = 1'b1;
                                end else begin
                                    n_phase = PH_CONTENT;
                                end
                            end
                        end
                        if (want_close) n_phase = PH_TAG;
                        // Clear the last flag when a second event or a close follows.
                        if (have2 || want_close) e1.last_result = 1'b0;
                        if (rst) n_phase = (ph == PH_TAG && !n_err && !do_fin &&
                            !have1) ? PH_LEN1 : n_phase;
                    end
                    n_lvl = lvl;
                    if (have1) begin
                        n_out = e1; n_ov = 1'b1;
                    end
                    if (have2) n_st = S_EV2;
                    else if (want_close) n_st = S_CLOSE;
                end
            end
            S_EV2: begin
                if (w_out_free) begin
                    n_out = n_pend; n_out.last_result = !w_close_now; n_ov = 1'b1;
                    n_st = w_close_now ? S_CLOSE : S_IDLE;
                end
            end
            default: begin
                if (!w_close_now) begin
                    n_st = S_IDLE;
                end else if (w_out_free) begin
                    n_lvl = r_lvl - 1'b1;
                    n_out = mk(EV_CLOSE, r_ctag[w_top], '0, n_lvl, '0, '0,
                        ERR_LEN_FORM, 1'b0);
                    n_out.last_result = !((n_lvl != '0) &&
                        (r_cend[IdxW'(n_lvl - 1'b1)] == r_pos));
                    n_ov = 1'b1;
                    if (n_out.last_result) n_st = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_cend[IdxW'(n_lvl - 1'b1)] <= w_push_end;
            r_ctag[IdxW'(n_lvl - 1'b1)] <= n_tag;
        end
        r_out  <= n_out;
        r_pend <= n_pend;
        r_tag <= n_tag; r_len <= n_len; r_lbl <= n_lbl; r_cleft <= n_cleft;
        r_acc <= n_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_phase <= PH_TAG; r_pos <= '0; r_lvl <= '0;
            r_err <= 1'b0; r_ov <= 1'b0;
        end else begin
            r_st <= n_st; r_phase <= n_phase; r_pos <= n_pos; r_lvl <= n_lvl;
            r_err <= n_err; r_ov <= n_ov;
        end
    end

    `BTP_ASSERT_IMPL(a_lvl_bound, i_clk, i_rst_n, 1'b1, r_lvl <= DepW'(MaxDepth), "depth over max")
    `BTP_ASSERT_IMPL(a_pop_idle, i_clk, i_rst_n, o_pop, r_st == S_IDLE, "pop while busy")
    `BTP_ASSERT_NEXT(a_hold, i_clk, i_rst_n, r_ov && !i_ready, r_ov && $stable(r_out), "item dropped")
endmodule

// ===== design/btp_front.sv =====
`include "ber_tlv_stream_parser_core_assert.svh"
module btp_front import btp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    btp_in_if.sink s_in,
    input  logic i_full,
    output logic o_push,
    output t_cmd o_cmd
);
    // Accept bytes into the queue while it has room.
    assign s_in.ready = !i_full;
    assign o_push = s_in.valid && !i_full;
    assign o_cmd.data_byte = s_in.payload.data_byte;
    assign o_cmd.frame_start = s_in.payload.frame_start;

    `BTP_ASSERT_IMPL(a_no_push_full, i_clk, i_rst_n, i_full, !o_push, "push while full")
    `BTP_ASSERT_IMPL(a_push_hs, i_clk, i_rst_n, o_push, s_in.valid && s_in.ready, "push off handshake")
    `BTP_ASSERT_IMPL(a_full_stall, i_clk, i_rst_n, i_full, !s_in.ready, "ready while full")
endmodule

// ===== design/ber_tlv_stream_parser_core.sv =====
// Channel | Dir | Payload
// s_in    | in  | data_byte[7:0], frame_start
// m_out   | out | event_kind, tag, elem_length, depth, content_byte, int_value, error, last
// Flow: while idle and its output is free, the engine takes one byte from the queue per
// cycle; it loads one event per cycle into its output register while the output is free,
// and takes no new byte until all events of the last one are loaded.
// A four-entry queue between the byte intake and the event engine absorbs close runs.
// Reset: synchronous, active low; clears the queue, parser phase, depth and error hold.
// Stalls: a held output item stops the engine; the intake keeps filling the queue and
// drops ready while the queue is full.
module ber_tlv_stream_parser_core import btp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    btp_in_if.sink s_in,
    btp_out_if.source m_out
);
    logic w_full, w_push, w_pop, w_empty, w_busy;
    t_cmd w_cmd_in, w_cmd_out;

    // Intake: classify nothing beyond handshake, hold bytes in order.
    btp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_in(s_in),
        .i_full(w_full), .o_push(w_push), .o_cmd(w_cmd_in)
    );

    btp_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(w_push), .i_data(w_cmd_in), .o_full(w_full),
        .i_pop(w_pop), .o_empty(w_empty), .o_data(w_cmd_out)
    );

    // Engine: advance the parse and emit events through its output register.
    btp_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_empty(w_empty), .i_cmd(w_cmd_out), .o_pop(w_pop), .o_busy(w_busy),
        .o_valid(m_out.valid), .i_ready(m_out.ready), .o_item(m_out.payload)
    );

    `BTP_ASSERT_IMPL(a_pop_nonempty, i_clk, i_rst_n, w_pop, !w_empty, "pop from empty queue")
    `BTP_ASSERT_IMPL(a_busy_valid, i_clk, i_rst_n, m_out.valid, w_busy, "valid while idle")
    `BTP_ASSERT_IMPL(a_queue_flow, i_clk, i_rst_n, w_push, !w_full, "push into full queue")
endmodule
